// File: rtl/slbg_pkg.sv
// Types and constants shared by the status LED blink and glow block.
package slbg_pkg;

  localparam int unsigned DutyW = 17;
  localparam int unsigned PressW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned StepShift = 11;

  typedef enum logic [3:0] {
    MODE_TICK    = 4'd0,
    MODE_PERIOD  = 4'd1,
    MODE_COMPARE = 4'd2,
    MODE_BUTTON  = 4'd3,
    MODE_MESSAGE = 4'd4,
    MODE_STEADY  = 4'd5,
    MODE_GLOW    = 4'd6,
    MODE_OFF     = 4'd7,
    MODE_BTN_DIS = 4'd8
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PWM_PERIOD    = 3'd0,
    CFG_GLOW_FLOOR    = 3'd1,
    CFG_GLOW_STEP     = 3'd2,
    CFG_MESSAGE_PAUSE = 3'd3,
    CFG_MESSAGE_LEAD  = 3'd4,
    CFG_BUTTON_HOLD   = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] PwmPeriodRst = 16'd30000;
  localparam logic [15:0] GlowFloorRst = 16'd35;
  localparam logic [7:0]  GlowStepRst = 8'd75;
  localparam logic [3:0]  MsgPauseRst = 4'd8;
  localparam logic [2:0]  MsgLeadRst = 3'd4;
  localparam logic [2:0]  BtnHoldRst = 3'd2;
  localparam logic [DutyW-1:0] DutyRst = 17'd100;
  localparam logic [DutyW-1:0] DutyMax = 17'h1FFFF;

  typedef struct packed {
    logic [15:0] pwm_period;
    logic [15:0] glow_floor;
    logic [7:0]  glow_step;
    logic [3:0]  message_pause;
    logic [2:0]  message_lead;
    logic [2:0]  button_hold;
  } cfg_t;

  typedef struct packed {
    logic [3:0] mode;
    logic [3:0] message_code;
  } evt_t;

  typedef struct packed {
    logic              led_on;
    logic [DutyW-1:0]  duty_value;
    logic [PressW-1:0] press_count;
  } res_t;

endpackage

// File: rtl/slbg_if.sv
// Event and result channel interfaces of the status LED block.
interface slbg_evt_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic [3:0] message_code;

  modport source (output valid, output mode, output message_code, input ready);
  modport sink (input valid, input mode, input message_code, output ready);
endinterface

interface slbg_res_if;
  logic        valid;
  logic        ready;
  logic        led_on;
  logic [16:0] duty_value;
  logic [15:0] press_count;

  modport source (output valid, output led_on, output duty_value, output press_count,
                  input ready);
  modport sink (input valid, input led_on, input duty_value, input press_count,
                output ready);
endinterface

// File: rtl/slbg_cfg.sv
// Configuration register bank of the status LED block.
module slbg_cfg import slbg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PWM_PERIOD:    cfg_d.pwm_period = cfg_wdata_i;
        CFG_GLOW_FLOOR:    cfg_d.glow_floor = cfg_wdata_i;
        CFG_GLOW_STEP:     cfg_d.glow_step = cfg_wdata_i[7:0];
        CFG_MESSAGE_PAUSE: cfg_d.message_pause = cfg_wdata_i[3:0];
        CFG_MESSAGE_LEAD:  cfg_d.message_lead = cfg_wdata_i[2:0];
        CFG_BUTTON_HOLD:   cfg_d.button_hold = cfg_wdata_i[2:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period    <= PwmPeriodRst;
      cfg_q.glow_floor    <= GlowFloorRst;
      cfg_q.glow_step     <= GlowStepRst;
      cfg_q.message_pause <= MsgPauseRst;
      cfg_q.message_lead  <= MsgLeadRst;
      cfg_q.button_hold   <= BtnHoldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/slbg_core.sv
// LED state, blink code sequencer and glow ramp; one item per step.
module slbg_core import slbg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  evt_t evt_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  logic              led_q, led_d;
  logic [DutyW-1:0]  duty_q, duty_d;
  logic              falling_q, falling_d;
  logic [2:0]        hold_q, hold_d;
  logic [4:0]        pulses_q, pulses_d;
  logic [5:0]        pos_q, pos_d;
  logic              blink_en_q, blink_en_d;
  logic              glow_en_q, glow_en_d;
  logic              btn_en_q, btn_en_d;
  logic [PressW-1:0] press_q, press_d;

  // blink tick
  logic signed [6:0] pos_inc;
  logic [5:0]        pos_next;

  // glow ramp
  logic              ramp_flip;
  logic              fall_now;
  logic [24:0]       prod;
  logic [25:0]       prod_up;
  logic [DutyW:0]    rise_sum;
  logic [DutyW-1:0]  duty_ramp;

  always_comb begin
    pos_inc = $signed({pos_q[5], pos_q}) + 7'sd1;
    if (pos_inc >= $signed({2'b00, pulses_q})) begin
      pos_next = 6'd0 - {2'b00, cfg_i.message_pause};
    end else begin
      pos_next = pos_inc[5:0];
    end
  end

  always_comb begin
    ramp_flip = (duty_q >= {1'b0, cfg_i.pwm_period}) ||
                ((duty_q < {1'b0, cfg_i.glow_floor}) && falling_q);
    fall_now  = falling_q ^ ramp_flip;
    prod      = cfg_i.glow_step * duty_q;
    prod_up   = {1'b0, prod} + 26'd2047;
    rise_sum  = {1'b0, duty_q} + {4'd0, prod[24:StepShift]};
    if (fall_now) begin
      // ceiling of the step never exceeds the duty, so no underflow
      duty_ramp = duty_q - {2'd0, prod_up[25:StepShift]};
    end else if (rise_sum[DutyW]) begin
      duty_ramp = DutyMax;
    end else begin
      duty_ramp = rise_sum[DutyW-1:0];
    end
  end

  always_comb begin
    led_d      = led_q;
    duty_d     = duty_q;
    falling_d  = falling_q;
    hold_d     = hold_q;
    pulses_d   = pulses_q;
    pos_d      = pos_q;
    blink_en_d = blink_en_q;
    glow_en_d  = glow_en_q;
    btn_en_d   = btn_en_q;
    press_d    = press_q;
    case (mode_e'(evt_i.mode))
      MODE_TICK: begin
        if (blink_en_q) begin
          if (hold_q != 3'd0) begin
            hold_d = hold_q - 3'd1;
          end else if (pulses_q == 5'd0) begin
            led_d = ~led_q;
          end else begin
            if (!pos_q[5]) led_d = ~led_q;
            pos_d = pos_next;
          end
        end
      end
      MODE_PERIOD: begin
        if (glow_en_q) begin
          falling_d = fall_now;
          duty_d    = duty_ramp;
          led_d     = 1'b1;
        end
      end
      MODE_COMPARE: begin
        if (glow_en_q) led_d = 1'b0;
      end
      MODE_BUTTON: begin
        if (btn_en_q) begin
          press_d = press_q + PressW'(1);
          led_d   = 1'b1;
          hold_d  = cfg_i.button_hold;
        end
      end
      MODE_MESSAGE: begin
        glow_en_d  = 1'b0;
        led_d      = 1'b0;
        blink_en_d = 1'b1;
        hold_d     = cfg_i.message_lead;
        pulses_d   = {evt_i.message_code, 1'b0};
      end
      MODE_STEADY: begin
        pulses_d   = 5'd0;
        glow_en_d  = 1'b0;
        blink_en_d = 1'b1;
      end
      MODE_GLOW: begin
        glow_en_d = 1'b1;
      end
      MODE_OFF: begin
        glow_en_d  = 1'b0;
        blink_en_d = 1'b0;
        led_d      = 1'b0;
      end
      MODE_BTN_DIS: begin
        btn_en_d = 1'b0;
      end
      default: begin
        led_d = led_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q      <= 1'b1;
      duty_q     <= DutyRst;
      falling_q  <= 1'b0;
      hold_q     <= 3'd0;
      pulses_q   <= 5'd0;
      pos_q      <= 6'd0;
      blink_en_q <= 1'b0;
      glow_en_q  <= 1'b0;
      btn_en_q   <= 1'b1;
      press_q    <= '0;
    end else if (step_i) begin
      led_q      <= led_d;
      duty_q     <= duty_d;
      falling_q  <= falling_d;
      hold_q     <= hold_d;
      pulses_q   <= pulses_d;
      pos_q      <= pos_d;
      blink_en_q <= blink_en_d;
      glow_en_q  <= glow_en_d;
      btn_en_q   <= btn_en_d;
      press_q    <= press_d;
    end
  end

  // result reflects the state after this item
  assign res_o.led_on      = led_d;
  assign res_o.duty_value  = duty_d;
  assign res_o.press_count = press_d;

endmodule

// File: rtl/status_led_blink_code_and_glow.sv
// Top level of the status LED blink code and breathing glow block.
//
//  channel   dir  handshake        payload
//  evt_i     in   valid/ready      mode[3:0], message_code[3:0]
//  res_o     out  valid/ready      led_on, duty_value[16:0], press_count[15:0]
//  cfg       in   cfg_we_i         cfg_idx_i[2:0], cfg_wdata_i[15:0]
//
// One item per cycle sustained while the result side is not stalled; an item goes from acceptance to result valid
// through an input register, then the state update (8x17 duty multiply) into the result register.
// A stalled result holds the pipe; the input register still takes one item meanwhile if it is empty.
// Reset restores valid flags, config and LED state but not the data registers; no item is lost across a stall.
module status_led_blink_code_and_glow import slbg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  slbg_evt_if.sink            evt_i,
  slbg_res_if.source          res_o
);

  cfg_t cfg;
  evt_t evt_q;
  logic evt_vld_q;
  res_t res, res_q;
  logic res_vld_q;
  logic advance;
  logic step;

  slbg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign advance     = !res_vld_q || res_o.ready;
  assign step        = evt_vld_q && advance;
  assign evt_i.ready = !evt_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (evt_i.ready) evt_vld_q <= evt_i.valid;
      if (advance) res_vld_q <= evt_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      evt_q.mode         <= evt_i.mode;
      evt_q.message_code <= evt_i.message_code;
    end
    if (step) res_q <= res;
  end

  slbg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .evt_i  (evt_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign res_o.valid       = res_vld_q;
  assign res_o.led_on      = res_q.led_on;
  assign res_o.duty_value  = res_q.duty_value;
  assign res_o.press_count = res_q.press_count;

endmodule

// File: rtl/slbg_checker.sv
// Port-level checks of the status LED block, bound to its top level.
module slbg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        evt_valid,
  input logic        evt_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_led_on,
  input logic [16:0] res_duty_value,
  input logic [15:0] res_press_count
);

  logic        seen_q;
  logic [15:0] last_press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_press_q <= '0;
    end else if (res_valid && res_ready) begin
      seen_q       <= 1'b1;
      last_press_q <= res_press_count;
    end
  end

  // a stalled result keeps its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_led_on) &&
      $stable(res_duty_value) && $stable(res_press_count))
    else $error("result changed while stalled");

  // an empty output side never blocks the input
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid |-> evt_ready)
    else $error("input blocked with empty output");

  // an item accepted with the sink ready next cycle then shows its result as valid
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_valid && evt_ready ##1 res_ready) |=> res_valid)
    else $error("result missing after accepted item");

  // one item counts at most one press
  a_press_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready && seen_q |->
      (res_press_count == last_press_q) || (res_press_count == last_press_q + 16'd1))
    else $error("press count jumped");

endmodule

bind status_led_blink_code_and_glow slbg_checker u_slbg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .evt_valid       (evt_i.valid),
  .evt_ready       (evt_i.ready),
  .res_valid       (res_o.valid),
  .res_ready       (res_o.ready),
  .res_led_on      (res_o.led_on),
  .res_duty_value  (res_o.duty_value),
  .res_press_count (res_o.press_count)
);

// File: tb/sv/status_led_blink_code_and_glow_tb.sv
// Testbench for the status LED blink code and breathing glow block.
module status_led_blink_code_and_glow_tb;
  import slbg_pkg::*;

  localparam int ItemTarget = 1130;
  localparam logic [3:0] ModeSpareLo = 4'd9;
  localparam logic [3:0] ModeSpareHi = 4'd15;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  slbg_evt_if evt_if ();
  slbg_res_if res_if ();

  status_led_blink_code_and_glow dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_i       (evt_if),
    .res_o       (res_if)
  );

  // LED state mirror
  cfg_t             regs;
  logic             lamp_lit;
  logic [DutyW-1:0] duty;
  logic             ramp_down;
  logic [2:0]       hold_left;
  logic [4:0]       pulses_per_code;
  logic [5:0]       pulse_pos;
  logic             blink_on;
  logic             glow_on;
  logic             button_on;
  logic [15:0]      press_total;

  res_t led_expect_q[$];
  int   mismatch_count = 0;
  int   sent_count = 0;
  int   checked_count = 0;
  int   phase_count = 0;
  int   evt_gap_max = 14;
  int   res_stall_max = 14;

  always #5 clk_i = ~clk_i;

  initial begin
    #8_000_000;
    $display("Timeout: block stopped producing results");
    $display("Mismatches found");
    $finish;
  end

  function automatic res_t next_led_state(logic [3:0] mode, logic [3:0] code);
    int          pos;
    logic [31:0] prod;
    logic [31:0] sum;
    res_t        r;
    case (mode)
      MODE_TICK: begin
        if (blink_on) begin
          if (hold_left != 0) begin
            hold_left = hold_left - 3'd1;
          end else if (pulses_per_code == 0) begin
            lamp_lit = ~lamp_lit;
          end else begin
            // negative position is the pause between repeats
            pos = int'($signed(pulse_pos));
            if (pos >= 0) lamp_lit = ~lamp_lit;
            pos = pos + 1;
            if (pos >= int'(pulses_per_code)) pos = -int'(regs.message_pause);
            pulse_pos = pos[5:0];
          end
        end
      end
      MODE_PERIOD: begin
        if (glow_on) begin
          if (duty >= regs.pwm_period || (duty < regs.glow_floor && ramp_down)) begin
            ramp_down = ~ramp_down;
          end
          prod = regs.glow_step * duty;
          if (ramp_down) begin
            duty = duty - DutyW'((prod + 32'd2047) >> StepShift);
          end else begin
            sum = duty + (prod >> StepShift);
            duty = (sum > DutyMax) ? DutyMax : sum[DutyW-1:0];
          end
          lamp_lit = 1'b1;
        end
      end
      MODE_COMPARE: begin
        if (glow_on) lamp_lit = 1'b0;
      end
      MODE_BUTTON: begin
        if (button_on) begin
          press_total = press_total + 16'd1;
          lamp_lit = 1'b1;
          hold_left = regs.button_hold;
        end
      end
      MODE_MESSAGE: begin
        glow_on = 1'b0;
        lamp_lit = 1'b0;
        blink_on = 1'b1;
        hold_left = regs.message_lead;
        pulses_per_code = {code, 1'b0};
      end
      MODE_STEADY: begin
        pulses_per_code = '0;
        glow_on = 1'b0;
        blink_on = 1'b1;
      end
      MODE_GLOW: glow_on = 1'b1;
      MODE_OFF: begin
        glow_on = 1'b0;
        blink_on = 1'b0;
        lamp_lit = 1'b0;
      end
      MODE_BTN_DIS: button_on = 1'b0;
      default: ;
    endcase
    r.led_on = lamp_lit;
    r.duty_value = duty;
    r.press_count = press_total;
    return r;
  endfunction

  // one item on the event channel; the expectation is formed at acceptance
  task automatic send_event(logic [3:0] mode, logic [3:0] code);
    int gap;
    gap = $urandom_range(0, evt_gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    evt_if.valid <= 1'b1;
    evt_if.mode <= mode;
    evt_if.message_code <= code;
    do @(posedge clk_i); while (evt_if.ready !== 1'b1);
    led_expect_q.push_back(next_led_state(mode, code));
    sent_count++;
  endtask

  // timer, compare, button or unused strobe that leaves the mode alone
  task automatic send_noise();
    logic [3:0] mode;
    case ($urandom_range(0, 4))
      0: mode = MODE_TICK;
      1: mode = MODE_PERIOD;
      2: mode = MODE_COMPARE;
      3: mode = MODE_BUTTON;
      default: mode = 4'($urandom_range(ModeSpareLo, ModeSpareHi));
    endcase
    send_event(mode, 4'($urandom));
  endtask

  // any mode except the permanent button disable
  task automatic send_any_but_disable();
    logic [3:0] mode;
    mode = 4'($urandom_range(0, 14));
    if (mode >= 4'(MODE_BTN_DIS)) mode = mode + 4'd1;
    send_event(mode, 4'($urandom));
  endtask

  task automatic settle_block();
    @(negedge clk_i);
    evt_if.valid <= 1'b0;
    wait (led_expect_q.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  // unused upper data bits get random values; the register keeps only its width
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] field, int width);
    logic [31:0] mask;
    logic [31:0] data;
    mask = (32'd1 << width) - 32'd1;
    data = ($urandom & ~mask) | (32'(field) & mask);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data[15:0];
    @(posedge clk_i);
  endtask

  task automatic set_config(cfg_t c);
    write_reg(CFG_PWM_PERIOD, c.pwm_period, 16);
    write_reg(CFG_GLOW_FLOOR, c.glow_floor, 16);
    write_reg(CFG_GLOW_STEP, 16'(c.glow_step), 8);
    write_reg(CFG_MESSAGE_PAUSE, 16'(c.message_pause), 4);
    write_reg(CFG_MESSAGE_LEAD, 16'(c.message_lead), 3);
    write_reg(CFG_BUTTON_HOLD, 16'(c.button_hold), 3);
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? CfgIdxSpareHi : CfgIdxSpareLo, 16'($urandom), 16);
    end
    regs = c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_value(int width);
    logic [31:0] mask;
    mask = (32'd1 << width) - 32'd1;
    case ($urandom_range(0, 3))
      0: return '0;
      1: return mask[15:0];
      default: return 16'($urandom & mask);
    endcase
  endfunction

  task automatic start_phase();
    cfg_t c;
    settle_block();
    c.pwm_period = pick_value(16);
    c.glow_floor = pick_value(16);
    c.glow_step = 8'(pick_value(8));
    c.message_pause = 4'(pick_value(4));
    c.message_lead = 3'(pick_value(3));
    c.button_hold = 3'(pick_value(3));
    set_config(c);
    evt_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
    res_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
    phase_count++;
  endtask

  task automatic test_directed_cases();
    // glow and blink disabled: strobes change nothing
    send_event(MODE_COMPARE, 4'd0);
    send_event(MODE_PERIOD, 4'd0);
    send_event(MODE_TICK, 4'd0);
    send_event(ModeSpareLo, 4'd15);
    send_event(ModeSpareHi, 4'd15);
    send_event(MODE_GLOW, 4'd0);
    send_event(MODE_PERIOD, 4'd0);
    send_event(MODE_COMPARE, 4'd0);
    send_event(MODE_PERIOD, 4'd0);
    send_event(MODE_BUTTON, 4'd0);
    // largest code: lead-in hold, then pulses
    send_event(MODE_MESSAGE, 4'd15);
    repeat (5) send_event(MODE_TICK, 4'd15);
    // code zero falls back to a steady toggle after the hold
    send_event(MODE_MESSAGE, 4'd0);
    repeat (5) send_event(MODE_TICK, 4'd0);
    send_event(MODE_STEADY, 4'd0);
    send_event(MODE_TICK, 4'd0);
    send_event(MODE_OFF, 4'd0);
    send_event(MODE_TICK, 4'd0);
  endtask

  task automatic test_blink_codes();
    logic [3:0] code;
    int         n;
    start_phase();
    repeat ($urandom_range(1, 3)) begin
      code = 4'($urandom);
      send_event(MODE_MESSAGE, code);
      n = regs.message_lead + $urandom_range(1, 2) * (2 * code + regs.message_pause)
          + $urandom_range(0, 3);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0) send_noise();
        else send_event(MODE_TICK, 4'($urandom));
      end
    end
  endtask

  task automatic test_steady_blink();
    start_phase();
    send_event(MODE_STEADY, 4'($urandom));
    repeat ($urandom_range(20, 60)) begin
      case ($urandom_range(0, 9))
        0: send_event(MODE_BUTTON, 4'($urandom));
        1: send_noise();
        default: send_event(MODE_TICK, 4'($urandom));
      endcase
    end
  endtask

  task automatic test_glow_ramp();
    start_phase();
    send_event(MODE_GLOW, 4'($urandom));
    repeat ($urandom_range(20, 80)) begin
      send_event(MODE_PERIOD, 4'($urandom));
      if ($urandom_range(0, 2) != 0) send_event(MODE_COMPARE, 4'($urandom));
      if ($urandom_range(0, 15) == 0) send_noise();
    end
  endtask

  task automatic test_mixed_events();
    start_phase();
    repeat ($urandom_range(30, 60)) send_any_but_disable();
  endtask

  task automatic test_button_disable();
    start_phase();
    repeat (5) send_event(MODE_BUTTON, 4'($urandom));
    send_event(MODE_BTN_DIS, 4'($urandom));
    repeat (40) begin
      case ($urandom_range(0, 3))
        0: send_event(MODE_BUTTON, 4'($urandom));
        1: send_event(MODE_BTN_DIS, 4'($urandom));
        default: send_any_but_disable();
      endcase
    end
  endtask

  // result receiver: random stall before each item
  initial begin
    res_if.ready = 1'b0;
    forever begin
      int stall;
      stall = $urandom_range(0, res_stall_max);
      @(negedge clk_i);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (led_expect_q.size() == 0) begin
        $error("result item with no event pending");
        mismatch_count++;
      end else begin
        want = led_expect_q.pop_front();
        checked_count++;
        if (res_if.led_on !== want.led_on) begin
          $error("led_on: expected %0d, actual %0d", want.led_on, res_if.led_on);
          mismatch_count++;
        end
        if (res_if.duty_value !== want.duty_value) begin
          $error("duty_value: expected %0d, actual %0d", want.duty_value, res_if.duty_value);
          mismatch_count++;
        end
        if (res_if.press_count !== want.press_count) begin
          $error("press_count: expected %0d, actual %0d", want.press_count,
                 res_if.press_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    evt_if.valid = 1'b0;
    evt_if.mode = '0;
    evt_if.message_code = '0;

    regs.pwm_period = PwmPeriodRst;
    regs.glow_floor = GlowFloorRst;
    regs.glow_step = GlowStepRst;
    regs.message_pause = MsgPauseRst;
    regs.message_lead = MsgLeadRst;
    regs.button_hold = BtnHoldRst;
    lamp_lit = 1'b1;
    duty = DutyRst;
    ramp_down = 1'b0;
    hold_left = '0;
    pulses_per_code = '0;
    pulse_pos = '0;
    blink_on = 1'b0;
    glow_on = 1'b0;
    button_on = 1'b1;
    press_total = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    while (sent_count < ItemTarget) begin
      test_blink_codes();
      test_steady_blink();
      test_glow_ramp();
      test_mixed_events();
    end
    test_button_disable();

    settle_block();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d events over %0d register settings with random idle on both sides",
             sent_count, phase_count);
    $display("Checked %0d result items: blink codes, steady blink, glow ramp, buttons",
             checked_count);
    if (mismatch_count == 0 && led_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (led_expect_q.size() != 0) $error("%0d results never arrived", led_expect_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/slbg_pkg.sv
rtl/slbg_if.sv
rtl/slbg_cfg.sv
rtl/slbg_core.sv
rtl/status_led_blink_code_and_glow.sv
rtl/slbg_checker.sv
tb/sv/status_led_blink_code_and_glow_tb.sv
